[sv/c231h_pkg.sv]
// ----------------------------------------------------------------------------
// c231h_pkg
// Shared types, constants and fixed-point helpers for the COST-231 Hata
// path loss pipeline.
// ----------------------------------------------------------------------------
package c231h_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 8;

    localparam int F_W     = 11;
    localparam int HB_W    = 8;
    localparam int HM_W    = 4;
    localparam int HM47_W  = 10;
    localparam int LOSS_W  = 16;
    localparam int IDX_W   = 2;

    localparam int L2_W    = 21;
    localparam int L10_W   = 20;
    localparam int Q_W     = 26;
    localparam int SUM_W   = 28;

    localparam int LOG_LAT  = 17;
    localparam int LOSS_LAT = 5;

    typedef enum logic [IDX_W-1:0] {
        REG_STATION_X = 2'd0,
        REG_STATION_Y = 2'd1,
        REG_CARRIER   = 2'd2,
        REG_HEIGHT    = 2'd3
    } reg_idx_t;

    localparam logic [30:0] LOG10_2_Q32 = 31'd1292913986;

    localparam logic [Q_W-1:0] K_46_3  = 26'd3034317;
    localparam logic [Q_W-1:0] K_33_9  = 26'd2221670;
    localparam logic [Q_W-1:0] K_13_82 = 26'd905708;
    localparam logic [Q_W-1:0] K_44_9  = 26'd2942566;
    localparam logic [Q_W-1:0] K_6_55  = 26'd429261;
    localparam logic [Q_W-1:0] K_3_20  = 26'd209715;
    localparam logic [Q_W-1:0] K_4_97  = 26'd325714;
    localparam logic [L2_W-1:0] L2_TWO = 21'd131072;

    // q16 by q16 product, rounded half up back to q16
    function automatic logic [35:0] mulq(input logic [Q_W-1:0] a, input logic [Q_W-1:0] b);
        logic [52:0] p;
        p = 53'(a) * 53'(b) + 53'd32768;
        return p[51:16];
    endfunction

    // log2 in q16 to log10 in q16, rounded
    function automatic logic [L10_W-1:0] l2_to_l10(input logic [L2_W-1:0] l2);
        logic [52:0] p;
        p = 53'(l2) * 53'(LOG10_2_Q32) + (53'd1 << 31);
        return p[32 +: L10_W];
    endfunction

endpackage

[sv/c231h_dist.sv]
// ----------------------------------------------------------------------------
// c231h_dist
// Integer link distance: absolute deltas, squares, sum and a pipelined
// digit-by-digit square root, one result bit per stage.
// ----------------------------------------------------------------------------
module c231h_dist #(
    parameter int COORD_BITS = 12
) (
    input  logic                  clk,
    input  logic [COORD_BITS-1:0] station_x,
    input  logic [COORD_BITS-1:0] station_y,
    input  logic [COORD_BITS-1:0] user_x,
    input  logic [COORD_BITS-1:0] user_y,
    output logic [COORD_BITS:0]   link_d
);
    localparam int C   = COORD_BITS;
    localparam int PW  = 2 * (C + 1);
    localparam int RMW = C + 4;

    logic [C-1:0]     dx_reg;
    logic [C-1:0]     dy_reg;
    logic [2*C-1:0]   dx2_reg;
    logic [2*C-1:0]   dy2_reg;
    logic [PW-1:0]    val_reg  [0:C+1];
    logic [C:0]       root_reg [0:C+1];
    logic [C+1:0]     rem_reg  [0:C+1];

    always_ff @(posedge clk)
    begin
        dx_reg     <= (station_x > user_x) ? station_x - user_x : user_x - station_x;
        dy_reg     <= (station_y > user_y) ? station_y - user_y : user_y - station_y;
        dx2_reg    <= dx_reg * dx_reg;
        dy2_reg    <= dy_reg * dy_reg;
        val_reg[0] <= PW'(dx2_reg) + PW'(dy2_reg);
        root_reg[0] <= '0;
        rem_reg[0]  <= '0;
    end

    for (genvar k = 0; k <= C; k++)
    begin : g_root
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        logic [RMW-1:0] diff;
        logic           ge;

        assign rem_t = {rem_reg[k], val_reg[k][PW-1-2*k -: 2]};
        assign trial = {1'b0, root_reg[k], 2'b01};
        assign diff  = rem_t - trial;
        assign ge    = rem_t >= trial;

        always_ff @(posedge clk)
        begin
            val_reg[k+1]  <= val_reg[k];
            root_reg[k+1] <= {root_reg[k][C-1:0], ge};
            rem_reg[k+1]  <= ge ? diff[C+1:0] : rem_t[C+1:0];
        end
    end

    assign link_d = root_reg[C+1];

endmodule

[sv/c231h_log.sv]
// ----------------------------------------------------------------------------
// c231h_log
// Pipelined log2 in q16: leading-one normalize, then sixteen squaring
// rounds, one fraction bit per stage.
// ----------------------------------------------------------------------------
module c231h_log #(
    parameter int IW = 12
) (
    input  logic                      clk,
    input  logic [IW-1:0]             v,
    output logic [$clog2(IW)+15:0]    l2
);
    localparam int NW = $clog2(IW);

    logic [IW-1:0] v1;
    logic [NW-1:0] n0;
    logic [30:0]   y0;

    logic [30:0]   y_reg    [0:16];
    logic [15:0]   frac_reg [0:16];
    logic [NW-1:0] n_reg    [0:16];

    always_comb
    begin
        v1 = (v == '0) ? IW'(1) : v;
        n0 = '0;
        for (int i = 0; i < IW; i++)
        begin
            if (v1[i])
            begin
                n0 = NW'(i);
            end
        end
        y0 = 31'(v1) << (5'd30 - 5'(n0));
    end

    always_ff @(posedge clk)
    begin
        y_reg[0]    <= y0;
        frac_reg[0] <= '0;
        n_reg[0]    <= n0;
    end

    for (genvar k = 0; k < 16; k++)
    begin : g_round
        logic [61:0] sq;
        logic [31:0] t;

        assign sq = y_reg[k] * y_reg[k];
        assign t  = sq[61:30];

        always_ff @(posedge clk)
        begin
            y_reg[k+1]    <= t[31] ? t[31:1] : t[30:0];
            frac_reg[k+1] <= {frac_reg[k][14:0], t[31]};
            n_reg[k+1]    <= n_reg[k];
        end
    end

    assign l2 = {n_reg[16], frac_reg[16]};

endmodule

[sv/c231h_loss.sv]
// ----------------------------------------------------------------------------
// c231h_loss
// Hata formula: log10 conversion, products, sum, rounding and saturation
// to the output format.
// ----------------------------------------------------------------------------
module c231h_loss #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            clk,
    input  logic [c231h_pkg::L2_W-1:0]      d_l2,
    input  logic [c231h_pkg::L2_W-1:0]      f_l2,
    input  logic [c231h_pkg::L2_W-1:0]      hb_l2,
    input  logic [c231h_pkg::L2_W-1:0]      hm_l2,
    output logic [c231h_pkg::LOSS_W-1:0]    loss_db
);
    import c231h_pkg::*;

    logic [L10_W-1:0]        ld_reg;
    logic [L10_W-1:0]        lf_reg;
    logic [L10_W-1:0]        lh_reg;
    logic [L10_W-1:0]        lm_reg;

    logic [Q_W-1:0]          sqlm_reg;
    logic [Q_W-1:0]          tf_reg;
    logic [Q_W-1:0]          th_reg;
    logic [Q_W-1:0]          bcoef_reg;
    logic [L10_W-1:0]        ld2_reg;

    logic [Q_W-1:0]          ahr_reg;
    logic [Q_W-1:0]          dl_reg;
    logic [Q_W-1:0]          tf3_reg;
    logic [Q_W-1:0]          th3_reg;

    logic signed [SUM_W-1:0] sum_reg;
    logic [LOSS_W-1:0]       loss_reg;

    logic [Q_W-1:0]          bterm;
    logic [SUM_W-1:0]        rsum;
    logic [SUM_W-1:0]        rnd;

    assign bterm = Q_W'(mulq(K_6_55, Q_W'(lh_reg)));

    always_comb
    begin
        rsum = sum_reg + (SUM_W'(1) << (15 - FRAC_BITS));
        rnd  = rsum >> (16 - FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        ld_reg <= l2_to_l10(d_l2);
        lf_reg <= l2_to_l10(f_l2);
        lh_reg <= l2_to_l10(hb_l2);
        lm_reg <= l2_to_l10(hm_l2 - L2_TWO);

        sqlm_reg  <= Q_W'(mulq(Q_W'(lm_reg), Q_W'(lm_reg)));
        tf_reg    <= Q_W'(mulq(K_33_9, Q_W'(lf_reg)));
        th_reg    <= Q_W'(mulq(K_13_82, Q_W'(lh_reg)));
        bcoef_reg <= (bterm > K_44_9) ? '0 : K_44_9 - bterm;
        ld2_reg   <= ld_reg;

        ahr_reg <= Q_W'(mulq(K_3_20, sqlm_reg));
        dl_reg  <= Q_W'(mulq(bcoef_reg, Q_W'(ld2_reg)));
        tf3_reg <= tf_reg;
        th3_reg <= th_reg;

        sum_reg <= SUM_W'(K_46_3) + SUM_W'(tf3_reg) - SUM_W'(th3_reg)
                   - SUM_W'(ahr_reg) + SUM_W'(K_4_97) + SUM_W'(dl_reg);

        if (sum_reg <= 0)
        begin
            loss_reg <= '0;
        end
        else if (rnd > SUM_W'(16'hFFFF))
        begin
            loss_reg <= '1;
        end
        else
        begin
            loss_reg <= rnd[LOSS_W-1:0];
        end
    end

    assign loss_db = loss_reg;

endmodule

[sv/cost231_hata_path_loss.sv]
// ----------------------------------------------------------------------------
// cost231_hata_path_loss
// COST-231 Hata urban path loss for one user position per cycle.
// ----------------------------------------------------------------------------
// throughput: one transfer per cycle, set by the fully pipelined sqrt and log2
// busy is always low; results leave on done for one cycle, no stall
// reset: valid pipeline cleared, registers at station 0,0, 1800 MHz, 30 m
module cost231_hata_path_loss #(
    parameter int COORD_BITS = c231h_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = c231h_pkg::FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  logic [c231h_pkg::IDX_W-1:0]            cfg_index,
    input  logic [(COORD_BITS > c231h_pkg::F_W ? COORD_BITS : c231h_pkg::F_W)-1:0] cfg_data,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [COORD_BITS-1:0]                  user_x,
    input  logic [COORD_BITS-1:0]                  user_y,
    input  logic [c231h_pkg::HM_W-1:0]             mobile_height_m,
    output logic                                   done,
    output logic [c231h_pkg::LOSS_W-1:0]           loss_db
);
    import c231h_pkg::*;

    localparam int DIST_LAT = COORD_BITS + 4;
    localparam int LAT      = DIST_LAT + LOG_LAT + LOSS_LAT;
    localparam int DW       = COORD_BITS + 1;
    localparam int DNW      = $clog2(DW);

    logic [COORD_BITS-1:0] station_x_reg;
    logic [COORD_BITS-1:0] station_y_reg;
    logic [F_W-1:0]        carrier_reg;
    logic [HB_W-1:0]       height_reg;
    logic [LAT-1:0]        vld_reg;
    logic [HM_W-1:0]       hm_reg [0:DIST_LAT-1];

    logic [DW-1:0]         link_d;
    logic [HM_W-1:0]       hm1;
    logic [HM47_W-1:0]     hm47;
    logic [DNW+15:0]       d_l2;
    logic [$clog2(F_W)+15:0]    f_l2;
    logic [$clog2(HB_W)+15:0]   hb_l2;
    logic [$clog2(HM47_W)+15:0] hm_l2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_x_reg <= '0;
            station_y_reg <= '0;
            carrier_reg   <= 11'd1800;
            height_reg    <= 8'd30;
            vld_reg       <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[LAT-2:0], start & ~busy};
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_STATION_X: station_x_reg <= cfg_data[COORD_BITS-1:0];
                    REG_STATION_Y: station_y_reg <= cfg_data[COORD_BITS-1:0];
                    REG_CARRIER:   carrier_reg   <= cfg_data[F_W-1:0];
                    REG_HEIGHT:    height_reg    <= cfg_data[HB_W-1:0];
                    default:       ;
                endcase
            end
        end
    end

    // mobile height rides along with the distance pipeline
    always_ff @(posedge clk)
    begin
        hm_reg[0] <= mobile_height_m;
        for (int i = 1; i < DIST_LAT; i++)
        begin
            hm_reg[i] <= hm_reg[i-1];
        end
    end

    assign hm1  = (hm_reg[DIST_LAT-1] == '0) ? HM_W'(1) : hm_reg[DIST_LAT-1];
    assign hm47 = HM47_W'(hm1) * HM47_W'(47);

    c231h_dist #(.COORD_BITS(COORD_BITS)) u_dist (
        .clk       (clk),
        .station_x (station_x_reg),
        .station_y (station_y_reg),
        .user_x    (user_x),
        .user_y    (user_y),
        .link_d    (link_d)
    );

    c231h_log #(.IW(DW))     u_log_d  (.clk(clk), .v(link_d),      .l2(d_l2));
    c231h_log #(.IW(F_W))    u_log_f  (.clk(clk), .v(carrier_reg), .l2(f_l2));
    c231h_log #(.IW(HB_W))   u_log_hb (.clk(clk), .v(height_reg),  .l2(hb_l2));
    c231h_log #(.IW(HM47_W)) u_log_hm (.clk(clk), .v(hm47),        .l2(hm_l2));

    c231h_loss #(.FRAC_BITS(FRAC_BITS)) u_loss (
        .clk     (clk),
        .d_l2    (L2_W'(d_l2)),
        .f_l2    (L2_W'(f_l2)),
        .hb_l2   (L2_W'(hb_l2)),
        .hm_l2   (L2_W'(hm_l2)),
        .loss_db (loss_db)
    );

    assign busy = 1'b0;
    assign done = vld_reg[LAT-1];

    a_done_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, LAT))
        else $error("done without a start transfer");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##LAT done)
        else $error("start transfer lost in pipeline");

    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(loss_db))
        else $error("result unknown at done");

endmodule
